// File: rtl/btff_pkg.sv
// Shared types, constants and tag helpers for the boundary-tag first-fit allocator.
// Depends on nothing; imported by boundary_tag_first_fit_allocator.
package btff_pkg;

	localparam int DEF_HEAP_BYTES  = 65536;
	localparam int DEF_CHUNK_BYTES = 4096;

	localparam int TAG_W  = 18;
	localparam int OFF_W  = 32;
	localparam int REQ_W  = 16;
	localparam int ADDR_W = 16;

	localparam logic [OFF_W-1:0] SIZE_MASK   = 32'h0003_FFF8;
	localparam logic [OFF_W-1:0] FIRST_BLOCK = 32'd8;
	localparam logic [OFF_W-1:0] MIN_BLOCK   = 32'd16;
	localparam logic [OFF_W-1:0] INIT_CHUNK  = 32'd4096;
	localparam logic [OFF_W-1:0] INIT_BREAK  = 32'd4112;

	typedef enum logic [1:0] {
		RES_OK      = 2'd0,
		RES_ZERO    = 2'd1,
		RES_NOSPACE = 2'd2
	} status_t;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	// pack size (multiple of 8) and allocated bit into one tag word
	function automatic logic [TAG_W-1:0] pack_tag(input logic [OFF_W-1:0] size, input logic used);
		return {size[17:3], 2'b00, used};
	endfunction

	function automatic logic [OFF_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
		return {14'd0, tag[17:3], 3'b000};
	endfunction

endpackage

// File: rtl/boundary_tag_first_fit_allocator.sv
// Boundary-tag first-fit heap allocator engine: tag memory, sequencer, result register.
// Depends on btff_pkg.
//
// Usage: each beat on the slave side is one request. tuser[0] selects allocate (0) or
// release (1); tdata carries request_size in [15:0] and block_address in [31:16]. Each
// request yields exactly one result beat: tdata is the payload offset of the allocated
// block (0 for release or failure), tuser the status (0 ok, 1 zero-size, 2 out of space).
// All block tags live in one single-port-read, single-port-write memory of HEAP_BYTES/4
// words with a registered read; every step of the allocator is a read of one tag
// followed by writes, so the tag memory port sets the rate. After reset the engine
// writes the prologue, the epilogue and the first 4096-byte free block, and takes no
// request meanwhile. An allocate reads the first tag, then walks the blocks in the
// first-fit search, then reads the chosen tag and makes 2 or 4 tag writes; when the
// heap must grow, add 3 writes and a coalesce of up to 2 writes. A release reads the
// tag, writes header and footer, then coalesces (up to 2 writes). The result then goes
// to the output register once that is free, which frees the engine for the next request
// even while the result beat waits to be taken.
module boundary_tag_first_fit_allocator
	import btff_pkg::*;
#(
	parameter int HEAP_BYTES  = DEF_HEAP_BYTES,
	parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] block_address
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] result_address
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int TAG_WORDS = HEAP_BYTES / 4;
	localparam int IDX_W     = $clog2(TAG_WORDS);
	localparam int HB_W      = $clog2(HEAP_BYTES + 1);
	localparam int LIMIT     = HEAP_BYTES / 8 + 2;
	localparam int SW        = $clog2(LIMIT + 1);

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE,
		ST_REL_RD, ST_REL_HDR, ST_REL_FTR,
		ST_FIT_RD, ST_FIT, ST_GROW,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
		ST_TAKE_RD, ST_TAKE, ST_WR, ST_DONE
	} state_t;

	state_t              state_q, cont_q;
	logic                take_q;
	logic [2:0]          init_q;
	logic [OFF_W-1:0]    bp_q, pv_q, sbp_q, hp_q, nh_q, sz_q, asize_q;
	logic                nused_q;
	logic [SW-1:0]       steps_q;
	logic [HB_W-1:0]     hb_q;
	logic [ADDR_W-1:0]   res_addr_q;
	status_t             res_st_q;
	logic [OFF_W-1:0]    wq_a_q [4];
	logic [TAG_W-1:0]    wq_d_q [4];
	logic [2:0]          wn_q;
	logic [1:0]          wi_q;
	logic                m_tvalid_q;
	logic [ADDR_W-1:0]   m_tdata_q;
	status_t             m_tuser_q;

	// tag memory
	logic [TAG_W-1:0]    mem [TAG_WORDS];
	logic [TAG_W-1:0]    rd_q;
	logic                rin_q;
	logic                re, we;
	logic [OFF_W-1:0]    ra, wa;
	logic [TAG_W-1:0]    wd;

	logic [TAG_W-1:0]    tag;
	logic [OFF_W-1:0]    tsz;
	logic                talloc;
	logic                walk_go, fits;
	logic [OFF_W-1:0]    ext, gsz, grow_end;

	function automatic logic in_rng(input logic [OFF_W-1:0] o);
		return {2'b00, o[OFF_W-1:2]} < OFF_W'(TAG_WORDS);
	endfunction

	// size seen by a read of a tag just written with size s
	function automatic logic [OFF_W-1:0] eff(input logic [OFF_W-1:0] o,
		input logic [OFF_W-1:0] s);
		return in_rng(o) ? (s & SIZE_MASK) : '0;
	endfunction

	// out-of-range reads give zero
	assign tag    = rin_q ? rd_q : '0;
	assign tsz    = tag_size(tag);
	assign talloc = tag[0];

	assign walk_go  = (tsz != '0) && (steps_q < SW'(LIMIT)) && (bp_q <= OFF_W'(HEAP_BYTES));
	assign fits     = !talloc && (asize_q <= tsz);
	assign ext      = (asize_q > OFF_W'(CHUNK_BYTES)) ? asize_q : OFF_W'(CHUNK_BYTES);
	assign gsz      = {ext[OFF_W-1:2] + {{(OFF_W-3){1'b0}}, ext[2]}, 2'b00};
	assign grow_end = OFF_W'(hb_q) + gsz;

	always_comb begin
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				case (init_q)
					3'd0: begin wa = 32'd0;    wd = '0; end
					3'd1: begin wa = 32'd4;    wd = pack_tag(32'd8, 1'b1); end
					3'd2: begin wa = 32'd8;    wd = pack_tag(32'd8, 1'b1); end
					3'd3: begin wa = 32'd12;   wd = pack_tag(INIT_CHUNK, 1'b0); end
					3'd4: begin wa = 32'd4104; wd = pack_tag(INIT_CHUNK, 1'b0); end
					3'd5: begin wa = 32'd4108; wd = pack_tag('0, 1'b1); end
					default: we = 1'b0;
				endcase
			end
			ST_REL_RD: begin re = 1'b1; ra = bp_q - 32'd4; end
			ST_REL_HDR: begin we = 1'b1; wa = bp_q - 32'd4; wd = pack_tag(tsz, 1'b0); end
			ST_REL_FTR: begin
				we = 1'b1;
				wa = bp_q + sz_q - 32'd8;
				wd = pack_tag(sz_q, 1'b0);
			end
			ST_FIT_RD: begin re = 1'b1; ra = FIRST_BLOCK - 32'd4; end
			ST_FIT: begin
				if (walk_go && !fits) begin
					re = 1'b1;
					ra = bp_q + tsz - 32'd4;
				end
			end
			ST_M0: begin re = 1'b1; ra = bp_q - 32'd8; end
			ST_M1: begin re = 1'b1; ra = bp_q - 32'd4; end
			ST_M2: begin re = 1'b1; ra = pv_q - 32'd4; end
			ST_M3: begin re = 1'b1; ra = bp_q + sbp_q - 32'd4; end
			ST_M4: begin re = 1'b1; ra = pv_q + hp_q - 32'd8; end
			ST_M5: begin
				if (!talloc && !nused_q) begin
					re = 1'b1;
					ra = bp_q + sbp_q + nh_q - 32'd8;
				end
			end
			ST_TAKE_RD: begin re = 1'b1; ra = bp_q - 32'd4; end
			ST_WR: begin we = 1'b1; wa = wq_a_q[wi_q]; wd = wq_d_q[wi_q]; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && in_rng(wa)) begin
			mem[wa[IDX_W+1:2]] <= wd;
		end
		if (re) begin
			rd_q  <= mem[ra[IDX_W+1:2]];
			rin_q <= in_rng(ra);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [OFF_W-1:0] req_ext, size, e1, bp2, rem;
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cont_q     <= ST_IDLE;
			take_q     <= 1'b0;
			init_q     <= '0;
			hb_q       <= HB_W'(INIT_BREAK);
			steps_q    <= '0;
			wn_q       <= '0;
			wi_q       <= '0;
			m_tvalid_q <= 1'b0;
			res_st_q   <= RES_OK;
		end else begin
			req_ext = {16'd0, s_tdata[15:0]};
			size    = '0;
			e1      = '0;
			bp2     = '0;
			rem     = '0;
			// drop the result beat once taken, unless a new one replaces it
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + 3'd1;
					if (init_q == 3'd5) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						res_addr_q <= '0;
						if (s_tuser[0] == ACT_RELEASE) begin
							res_st_q <= RES_OK;
							bp_q     <= {16'd0, s_tdata[31:16]};
							take_q   <= 1'b0;
							if (s_tdata[31:16] >= 16'd16 &&
							    OFF_W'(s_tdata[31:16]) < OFF_W'(hb_q) &&
							    s_tdata[18:16] == 3'd0) begin
								state_q <= ST_REL_RD;
							end else begin
								state_q <= ST_DONE;
							end
						end else if (s_tdata[15:0] == '0) begin
							res_st_q <= RES_ZERO;
							state_q  <= ST_DONE;
						end else begin
							res_st_q <= RES_OK;
							asize_q  <= (req_ext <= 32'd8) ? MIN_BLOCK
							            : ((req_ext + 32'd15) & ~32'd7);
							steps_q  <= '0;
							bp_q     <= FIRST_BLOCK;
							state_q  <= ST_FIT_RD;
						end
					end
				end
				ST_REL_RD: state_q <= ST_REL_HDR;
				ST_REL_HDR: begin
					sz_q    <= tsz;
					state_q <= ST_REL_FTR;
				end
				ST_REL_FTR: state_q <= ST_M0;
				ST_FIT_RD: state_q <= ST_FIT;
				ST_FIT: begin
					if (!walk_go) begin
						state_q <= ST_GROW;
					end else if (fits) begin
						state_q <= ST_TAKE_RD;
					end else begin
						bp_q    <= bp_q + tsz;
						steps_q <= steps_q + SW'(1);
					end
				end
				ST_GROW: begin
					if (grow_end > OFF_W'(HEAP_BYTES)) begin
						res_st_q <= RES_NOSPACE;
						state_q  <= ST_DONE;
					end else begin
						e1        = eff(OFF_W'(hb_q) - 32'd4, gsz);
						hb_q      <= grow_end[HB_W-1:0];
						bp_q      <= OFF_W'(hb_q);
						wq_a_q[0] <= OFF_W'(hb_q) - 32'd4;
						wq_d_q[0] <= pack_tag(gsz, 1'b0);
						wq_a_q[1] <= OFF_W'(hb_q) + e1 - 32'd8;
						wq_d_q[1] <= pack_tag(gsz, 1'b0);
						wq_a_q[2] <= OFF_W'(hb_q) + e1 - 32'd4;
						wq_d_q[2] <= pack_tag('0, 1'b1);
						wn_q      <= 3'd3;
						wi_q      <= '0;
						take_q    <= 1'b1;
						cont_q    <= ST_M0;
						state_q   <= ST_WR;
					end
				end
				ST_WR: begin
					if ({1'b0, wi_q} + 3'd1 == wn_q) begin
						wi_q    <= '0;
						state_q <= cont_q;
					end else begin
						wi_q <= wi_q + 2'd1;
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin pv_q <= bp_q - tsz; state_q <= ST_M2; end
				ST_M2: begin sbp_q <= tsz; state_q <= ST_M3; end
				ST_M3: begin hp_q <= tsz; state_q <= ST_M4; end
				ST_M4: begin
					nh_q    <= tsz;
					nused_q <= talloc;
					state_q <= ST_M5;
				end
				ST_M5: begin
					cont_q <= take_q ? ST_TAKE_RD : ST_DONE;
					wi_q   <= '0;
					if (talloc && nused_q) begin
						state_q <= take_q ? ST_TAKE_RD : ST_DONE;
					end else if (talloc) begin
						// merge with the next block
						size      = sbp_q + nh_q;
						wq_a_q[0] <= bp_q - 32'd4;
						wq_d_q[0] <= pack_tag(size, 1'b0);
						wq_a_q[1] <= bp_q + eff(bp_q - 32'd4, size) - 32'd8;
						wq_d_q[1] <= pack_tag(size, 1'b0);
						wn_q      <= 3'd2;
						state_q   <= ST_WR;
					end else if (nused_q) begin
						// merge with the previous block
						size      = sbp_q + tsz;
						wq_a_q[0] <= bp_q + sbp_q - 32'd8;
						wq_d_q[0] <= pack_tag(size, 1'b0);
						wq_a_q[1] <= pv_q - 32'd4;
						wq_d_q[1] <= pack_tag(size, 1'b0);
						wn_q      <= 3'd2;
						bp_q      <= pv_q;
						state_q   <= ST_WR;
					end else begin
						state_q <= ST_M6;
					end
				end
				ST_M6: begin
					// merge with both neighbours
					size      = sbp_q + hp_q + tsz;
					wq_a_q[0] <= pv_q - 32'd4;
					wq_d_q[0] <= pack_tag(size, 1'b0);
					wq_a_q[1] <= bp_q + sbp_q + nh_q - 32'd8;
					wq_d_q[1] <= pack_tag(size, 1'b0);
					wn_q      <= 3'd2;
					bp_q      <= pv_q;
					state_q   <= ST_WR;
				end
				ST_TAKE_RD: state_q <= ST_TAKE;
				ST_TAKE: begin
					res_addr_q <= bp_q[ADDR_W-1:0];
					res_st_q   <= RES_OK;
					wi_q       <= '0;
					cont_q     <= ST_DONE;
					state_q    <= ST_WR;
					if (tsz >= asize_q + MIN_BLOCK) begin
						// split: allocated front, free remainder behind it
						e1        = eff(bp_q - 32'd4, asize_q);
						bp2       = bp_q + e1;
						rem       = tsz - asize_q;
						wq_a_q[0] <= bp_q - 32'd4;
						wq_d_q[0] <= pack_tag(asize_q, 1'b1);
						wq_a_q[1] <= bp_q + e1 - 32'd8;
						wq_d_q[1] <= pack_tag(asize_q, 1'b1);
						wq_a_q[2] <= bp2 - 32'd4;
						wq_d_q[2] <= pack_tag(rem, 1'b0);
						wq_a_q[3] <= bp2 + eff(bp2 - 32'd4, rem) - 32'd8;
						wq_d_q[3] <= pack_tag(rem, 1'b0);
						wn_q      <= 3'd4;
					end else begin
						wq_a_q[0] <= bp_q - 32'd4;
						wq_d_q[0] <= pack_tag(tsz, 1'b1);
						wq_a_q[1] <= bp_q + eff(bp_q - 32'd4, tsz) - 32'd8;
						wq_d_q[1] <= pack_tag(tsz, 1'b1);
						wn_q      <= 3'd2;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_addr_q;
						m_tuser_q  <= res_st_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_break_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		OFF_W'(hb_q) <= OFF_W'(HEAP_BYTES))
		else $error("heap break beyond capacity");

	a_break_moves_on_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_GROW) |=> $stable(hb_q))
		else $error("heap break moved outside growth");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(LIMIT))
		else $error("first-fit walk passed its step limit");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != RES_OK) |-> (m_tdata == '0))
		else $error("failed request returned an address");

	a_no_read_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(re && we))
		else $error("tag read and write in one cycle");

endmodule
